[rtl/csvti_pkg.sv]
// Shared types and constants for the CSV column type inference block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package csvti_pkg;

    typedef enum logic [1:0] {
        TYPE_INT    = 2'd0,
        TYPE_FLOAT  = 2'd1,
        TYPE_STRING = 2'd2
    } t_col_type;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_SKIP   = 2'd2
    } t_phase;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [7:0] RESET_ROWS = 8'd5;

    // Controller to datapath
    typedef struct packed {
        logic take;       // consume the byte on the input port
        logic fin_close;  // close the cell left open by the end byte
        logic wr;         // merge the pending class into the column store
        logic emit_rd;    // read the column store at the emission index
        logic emit_load;  // load the output payload register
        logic emit_adv;   // step to the next column
        logic clear;      // return to the start-of-file state
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic closes;     // the byte on the input port closes a cell
        logic fin_needed; // a data row is still open
        logic out_last;   // the loaded result is the final column
    } t_status;

endpackage

`default_nettype wire

[rtl/csvti_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module csvti_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/csvti_ctrl.sv]
// Sequencing state machine: byte intake, column store update, result emission.
// Depends on csvti_pkg for the command and status structs.
`default_nettype none

module csvti_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_end_of_file,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output csvti_pkg::t_cmd        o_cmd,
    input  wire csvti_pkg::t_status i_status
);

    import csvti_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_FIN,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_eof, n_eof;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_eof       = r_eof;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_eof      = i_end_of_file;
                    if (i_status.closes) begin
                        n_state = S_WRITE;
                    end else if (i_end_of_file) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = r_eof ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (i_status.fin_needed) begin
                    o_cmd.fin_close = 1'b1;
                    n_state         = S_WRITE;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_cmd.emit_load = 1'b1;
                n_out_valid     = 1'b1;
                n_state         = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (i_status.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_eof       = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.emit_adv = 1'b1;
                        n_state        = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_eof       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_eof       <= n_eof;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/csvti_datapath.sv]
// Byte classing, row and column tracking, column type store and output payload.
// Depends on csvti_pkg and csvti_ram.
`default_nettype none

module csvti_datapath #(
    parameter int MAX_COLUMNS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [7:0]            i_file_byte,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [7:0]            i_cfg_wr_data,
    input  wire csvti_pkg::t_cmd       i_cmd,
    output csvti_pkg::t_status         o_status,
    output logic [5:0]                 o_column_index,
    output logic [1:0]                 o_column_type,
    output logic                       o_last_column
);

    import csvti_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    function automatic t_col_type cell_class(input logic empty, input logic dot,
                                             input logic text);
        t_col_type cls;
        if (empty || text) begin
            cls = TYPE_STRING;
        end else if (dot) begin
            cls = TYPE_FLOAT;
        end else begin
            cls = TYPE_INT;
        end
        return cls;
    endfunction

    logic [7:0]             r_rows_to_sample;
    t_phase                 r_phase;
    logic [CW-1:0]          r_col_count;
    logic [CW-1:0]          r_cur_col;
    logic [7:0]             r_rows_seen;
    logic                   r_empty;
    logic                   r_dot;
    logic                   r_text;
    logic                   r_row_open;
    logic [MAX_COLUMNS-1:0] r_valid;
    logic [AW-1:0]          r_emit_idx;
    logic [CW-1:0]          r_pend_col;
    t_col_type              r_pend_cls;
    logic [5:0]             r_out_index;
    t_col_type              r_out_type;
    logic                   r_out_last;

    logic          is_nl, is_comma, is_dot, is_num;
    logic          row_skip;
    logic [CW-1:0] col_eff;
    t_col_type     cur_cls;
    logic [AW-1:0] pend_idx;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_raddr;
    logic [1:0]    ram_rdata;
    t_col_type     old_type, merged_type;
    logic          emit_last;

    assign is_nl    = (i_file_byte == CHAR_NL);
    assign is_comma = (i_file_byte == CHAR_COMMA);
    assign is_dot   = (i_file_byte == CHAR_DOT);
    assign is_num   = (i_file_byte inside {[CHAR_ZERO:CHAR_NINE]}) ||
                      (i_file_byte == CHAR_MINUS);

    // A row opens on its first byte, unless the sample budget is spent.
    assign row_skip = !r_row_open && (r_rows_seen >= r_rows_to_sample);
    assign col_eff  = r_row_open ? r_cur_col : '0;
    assign cur_cls  = cell_class(r_empty, r_dot, r_text);

    assign o_status.closes     = (r_phase == PH_DATA) && !row_skip && (is_nl || is_comma);
    assign o_status.fin_needed = (r_phase == PH_DATA) && r_row_open;
    assign o_status.out_last   = r_out_last;

    // Column store: read on intake, write the widened class in the cycle after.
    assign pend_idx  = r_pend_col[AW-1:0];
    assign ram_re    = i_cmd.take || i_cmd.fin_close || i_cmd.emit_rd;
    assign ram_we    = i_cmd.wr && (r_pend_col < r_col_count);
    always_comb begin
        if (i_cmd.emit_rd) begin
            ram_raddr = r_emit_idx;
        end else if (i_cmd.fin_close) begin
            ram_raddr = r_cur_col[AW-1:0];
        end else begin
            ram_raddr = col_eff[AW-1:0];
        end
    end

    assign old_type    = r_valid[pend_idx] ? t_col_type'(ram_rdata) : TYPE_INT;
    assign merged_type = (r_pend_cls > old_type) ? r_pend_cls : old_type;

    csvti_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLUMNS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (pend_idx),
        .i_wdata (merged_type),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign emit_last = ((CW'(r_emit_idx) + CW'(1)) == r_col_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_to_sample <= RESET_ROWS;
            r_phase          <= PH_HEADER;
            r_col_count      <= CW'(1);
            r_cur_col        <= '0;
            r_rows_seen      <= '0;
            r_empty          <= 1'b1;
            r_dot            <= 1'b0;
            r_text           <= 1'b0;
            r_row_open       <= 1'b0;
            r_valid          <= '0;
            r_emit_idx       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rows_to_sample <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_phase     <= PH_HEADER;
                r_col_count <= CW'(1);
                r_cur_col   <= '0;
                r_rows_seen <= '0;
                r_empty     <= 1'b1;
                r_dot       <= 1'b0;
                r_text      <= 1'b0;
                r_row_open  <= 1'b0;
                r_valid     <= '0;
                r_emit_idx  <= '0;
            end else if (i_cmd.take) begin
                case (r_phase)
                    PH_HEADER: begin
                        if (is_nl) begin
                            r_phase <= PH_DATA;
                        end else if (is_comma && (r_col_count < CW'(MAX_COLUMNS))) begin
                            r_col_count <= r_col_count + CW'(1);
                        end
                    end
                    PH_DATA: begin
                        if (row_skip) begin
                            r_phase <= PH_SKIP;
                        end else begin
                            if (!r_row_open) begin
                                r_rows_seen <= r_rows_seen + 8'd1;
                            end
                            if (is_nl || is_comma) begin
                                r_empty <= 1'b1;
                                r_dot   <= 1'b0;
                                r_text  <= 1'b0;
                            end else begin
                                r_empty <= 1'b0;
                                if (is_dot) begin
                                    r_dot <= 1'b1;
                                end else if (!is_num) begin
                                    r_text <= 1'b1;
                                end
                            end
                            if (is_nl) begin
                                r_row_open <= 1'b0;
                                r_cur_col  <= '0;
                            end else begin
                                r_row_open <= 1'b1;
                                if (is_comma && (col_eff < CW'(MAX_COLUMNS))) begin
                                    r_cur_col <= col_eff + CW'(1);
                                end else begin
                                    r_cur_col <= col_eff;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.fin_close) begin
                r_row_open <= 1'b0;
                r_empty    <= 1'b1;
                r_dot      <= 1'b0;
                r_text     <= 1'b0;
            end else if (i_cmd.emit_adv) begin
                r_emit_idx <= r_emit_idx + AW'(1);
            end
            if (ram_we) begin
                r_valid[pend_idx] <= 1'b1;
            end
        end
    end

    // Pending close and output payload need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend_col <= col_eff;
            r_pend_cls <= cur_cls;
        end else if (i_cmd.fin_close) begin
            r_pend_col <= r_cur_col;
            r_pend_cls <= cur_cls;
        end
        if (i_cmd.emit_load) begin
            r_out_index <= 6'(r_emit_idx);
            r_out_type  <= r_valid[r_emit_idx] ? t_col_type'(ram_rdata) : TYPE_INT;
            r_out_last  <= emit_last;
        end
    end

    assign o_column_index = r_out_index;
    assign o_column_type  = r_out_type;
    assign o_last_column  = r_out_last;

endmodule

`default_nettype wire

[rtl/csv_column_type_inference.sv]
// CSV column type inference. Feed the file one byte per input transaction and
// flag the final byte with end_of_file. The first line's commas set the column
// count (saturating at MAX_COLUMNS); the next rows_to_sample lines are classed
// cell by cell as integer, float or string, each column keeping the widest
// class seen. After the end byte the block returns one result transaction per
// column in index order, the last one marked, then starts over for the next
// file with rows_to_sample kept. Sequencing: a byte that closes a cell (comma
// or newline in a sampled row) is followed by a write step, because the column
// type store is updated by a read-modify-write through its registered read port.
// The end byte is then followed by a check for a cell left open, which is closed
// through the same write step; then each result goes through a store read, a
// payload load and the output handshake, which waits while the output side
// holds ready low. No input is taken while results drain.
// Depends on csvti_pkg, csvti_ctrl, csvti_datapath and csvti_ram.
`default_nettype none

module csv_column_type_inference #(
    parameter int MAX_COLUMNS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration: rows_to_sample
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    // byte input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_file_byte,
    input  wire logic       i_end_of_file,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [5:0]      o_column_index,
    output logic [1:0]      o_column_type,
    output logic            o_last_column
);

    import csvti_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller: hold the input while a cell update or emission is running.
    csvti_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_end_of_file (i_end_of_file),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cmd         (cmd),
        .i_status      (status)
    );

    // Datapath: class bytes, track rows and columns, own the type store.
    csvti_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_file_byte    (i_file_byte),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_column_index (o_column_index),
        .o_column_type  (o_column_type),
        .o_last_column  (o_last_column)
    );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for csv_column_type_inference: streams CSV files one byte per
// transaction and checks every per-column result against a predictor kept inside tb_top.
// Depends on csvti_pkg and the csv_column_type_inference RTL.

module tb_top;
    import csvti_pkg::*;

    localparam int MAX_COLS   = 32;
    localparam int RAND_ITEMS = 120;     // random bytes that reach the header or a sampled row
    localparam int CALM_AFTER = 90;      // random bytes after which both sides stop idling
    localparam int MIN_FILES  = 4;
    localparam int RUN_LIMIT  = 200000;
    localparam logic [7:0] LETTER_A = 8'h61;

    typedef struct packed {
        logic [5:0] idx;
        t_col_type  typ;
        logic       last;
    } t_col_result;

    // One row of the directed table: a byte, its end flag, an optional typed
    // expectation, and an optional register write before the byte.
    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       typed;
        t_col_type  typ;
        logic       set_rows;
        logic [7:0] rows_val;
    } t_stim_row;

    typedef enum int {CELL_INT, CELL_FLOAT, CELL_TEXT, CELL_EMPTY} t_cell_kind;

    // DUT ports; every input starts at a known value.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_file_byte   = 8'd0;
    logic       i_end_of_file = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready   = 1'b0;
    logic [5:0] o_column_index;
    logic [1:0] o_column_type;
    logic       o_last_column;

    // Typed expectation that travels with the byte on the input port.
    logic      cur_typed = 1'b0;
    t_col_type cur_typ   = TYPE_INT;

    // Predictor state: a private copy of the register and of the block's state.
    logic [7:0]  rows_cfg;
    t_phase      ph;
    logic [6:0]  col_cnt;
    logic [6:0]  cur_col;
    logic [7:0]  rows_done;
    logic        c_empty;
    logic        c_dot;
    logic        c_text;
    logic        row_open;
    t_col_type   col_type [MAX_COLS];

    t_col_result exp_cols[$];    // column results still owed by the DUT
    t_col_result pred_cols[$];   // columns emitted by the latest byte
    t_stim_row   dir_rows[$];
    logic [7:0]  file_bytes[$];

    int cycles        = 0;
    int err_cnt       = 0;
    int live_items    = 0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int out_hold      = 0;
    bit idle_en       = 1'b1;

    csv_column_type_inference #(
        .MAX_COLUMNS(MAX_COLS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_file_byte    (i_file_byte),
        .i_end_of_file  (i_end_of_file),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_column_index (o_column_index),
        .o_column_type  (o_column_type),
        .o_last_column  (o_last_column)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return to the start-of-file state; the register is kept.
    task automatic clear_model();
        ph        = PH_HEADER;
        col_cnt   = 7'd1;
        cur_col   = 7'd0;
        rows_done = 8'd0;
        c_empty   = 1'b1;
        c_dot     = 1'b0;
        c_text    = 1'b0;
        row_open  = 1'b0;
        foreach (col_type[k]) col_type[k] = TYPE_INT;
    endtask

    // Class the finished cell and widen its column; cells past the header width are dropped.
    task automatic close_cell_model();
        t_col_type cls;
        if (c_empty || c_text)
            cls = TYPE_STRING;
        else if (c_dot)
            cls = TYPE_FLOAT;
        else
            cls = TYPE_INT;
        if (cur_col < col_cnt && cur_col < MAX_COLS) begin
            if (cls > col_type[cur_col])
                col_type[cur_col] = cls;
        end
        c_empty = 1'b1;
        c_dot   = 1'b0;
        c_text  = 1'b0;
    endtask

    task automatic data_byte_model(input logic [7:0] b);
        if (!row_open) begin
            // Once the sampled rows are used up, ignore everything up to the end byte.
            if (rows_done >= rows_cfg) begin
                ph = PH_SKIP;
                return;
            end
            row_open  = 1'b1;
            rows_done = rows_done + 8'd1;
            cur_col   = 7'd0;
        end
        if (b == CHAR_NL) begin
            close_cell_model();
            row_open = 1'b0;
            cur_col  = 7'd0;
        end else if (b == CHAR_COMMA) begin
            close_cell_model();
            if (cur_col < MAX_COLS)
                cur_col = cur_col + 7'd1;
        end else begin
            c_empty = 1'b0;
            if (b == CHAR_DOT)
                c_dot = 1'b1;
            else if (!((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_MINUS))
                c_text = 1'b1;
        end
    endtask

    // Advance the predictor by one accepted byte; fill pred_cols on the end byte.
    task automatic infer_byte(input logic [7:0] b, input logic eof);
        t_col_result res;
        int k;
        pred_cols.delete();
        if (ph == PH_HEADER) begin
            if (b == CHAR_NL)
                ph = PH_DATA;
            else if (b == CHAR_COMMA && col_cnt < MAX_COLS)
                col_cnt = col_cnt + 7'd1;
        end else if (ph == PH_DATA) begin
            data_byte_model(b);
        end
        if (eof) begin
            if (ph == PH_DATA && row_open)
                close_cell_model();
            for (k = 0; k < col_cnt && k < MAX_COLS; k++) begin
                res.idx  = 6'(k);
                res.typ  = col_type[k];
                res.last = (k + 1 == int'(col_cnt));
                pred_cols.push_back(res);
            end
            clear_model();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input t_col_result want);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] %s: expected col %0d type %0d last %0d, got col %0d type %0d last %0d",
                     $time, what, want.idx, want.typ, want.last,
                     o_column_index, o_column_type, o_last_column);
    endtask

    task automatic check_column();
        t_col_result want;
        if (exp_cols.size() == 0) begin
            want = '0;
            note_mismatch("result with nothing expected", want);
        end else begin
            want = exp_cols.pop_front();
            if (o_column_index !== want.idx || o_column_type !== want.typ ||
                o_last_column !== want.last)
                note_mismatch("column result mismatch", want);
        end
    endtask

    // Sample both channels at the rising edge; inputs only move at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                check_column();
            if (i_in_valid && o_in_ready) begin
                if (ph != PH_SKIP)
                    live_items++;
                infer_byte(i_file_byte, i_end_of_file);
                // A typed row in the directed table overrides the predictor's answer.
                if (cur_typed)
                    exp_cols.push_back({6'd0, cur_typ, 1'b1});
                else
                    foreach (pred_cols[k]) exp_cols.push_back(pred_cols[k]);
            end
        end
    end

    // Hard stop in case the DUT hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: while idling is enabled, randomly drop ready and keep it low while out_hold counts down.
    always @(negedge i_clk) begin
        if (out_hold != 0) begin
            out_hold <= out_hold - 1;
        end else if (idle_en && $urandom_range(0, 99) < out_stall_pct) begin
            i_out_ready <= 1'b0;
            out_hold    <= $urandom_range(0, 17);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Present one byte and hold it until the transaction completes.
    task automatic drive_item(input logic [7:0] b, input logic eof,
                              input logic typed, input t_col_type typ);
        if (idle_en && $urandom_range(0, 99) < in_gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 17)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_file_byte   <= b;
        i_end_of_file <= eof;
        cur_typed     <= typed;
        cur_typ       <= typ;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid after the end byte and wait for every column result to drain.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (exp_cols.size() != 0) @(negedge i_clk);
        // Let the block settle back to its start state before touching the register.
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_rows(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        rows_cfg = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_file();
        int k;
        for (k = 0; k < file_bytes.size(); k++)
            drive_item(file_bytes[k], k == file_bytes.size() - 1, 1'b0, TYPE_INT);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    task automatic add_typed(input logic [7:0] b, input t_col_type typ);
        t_stim_row row;
        row       = '0;
        row.data  = b;
        row.eof   = 1'b1;
        row.typed = 1'b1;
        row.typ   = typ;
        dir_rows.push_back(row);
    endtask

    // Append a whole file; the end flag goes on its last byte.
    task automatic add_text(input string s, input logic set_rows, input logic [7:0] rows_val);
        t_stim_row row;
        int k;
        for (k = 0; k < s.len(); k++) begin
            row          = '0;
            row.data     = s[k];
            row.eof      = (k == s.len() - 1);
            row.typ      = TYPE_INT;
            row.set_rows = set_rows && (k == 0);
            row.rows_val = rows_val;
            dir_rows.push_back(row);
        end
    endtask

    // ------------------------------------------------------------------
    // Random file generation
    // ------------------------------------------------------------------

    // Any byte that neither splits a cell nor ends a row.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        if ($urandom_range(0, 1))
            return LETTER_A + 8'($urandom_range(0, 25));
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_COMMA || b == CHAR_NL);
        return b;
    endfunction

    function automatic logic [7:0] num_byte();
        if ($urandom_range(0, 5) == 0)
            return CHAR_MINUS;
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic push_cell(input bit one_byte);
        t_cell_kind kind;
        int len;
        int pos;
        int k;
        kind = t_cell_kind'($urandom_range(0, 3));
        len  = one_byte ? 1 : $urandom_range(1, 3);
        pos  = $urandom_range(0, len - 1);
        if (kind != CELL_EMPTY) begin
            for (k = 0; k < len; k++) begin
                if (k == pos && kind == CELL_FLOAT)
                    file_bytes.push_back(CHAR_DOT);
                else if (k == pos && kind == CELL_TEXT)
                    file_bytes.push_back(text_byte());
                else
                    file_bytes.push_back(num_byte());
            end
        end
    endtask

    // Build one file: mostly well-formed CSV with random content, some raw noise,
    // and now and then a corrupted byte. A wide file overflows the column store.
    task automatic build_csv(input bit wide);
        int ncols;
        int nrows;
        int ncells;
        int r;
        int c;
        int k;
        bit final_nl;
        file_bytes.delete();
        if (!wide && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        ncols    = wide ? $urandom_range(MAX_COLS + 1, MAX_COLS + 8) : $urandom_range(1, 4);
        nrows    = wide ? 1 : $urandom_range(0, 3);
        final_nl = $urandom_range(0, 1);
        for (c = 0; c < ncols; c++) begin
            if (c > 0)
                file_bytes.push_back(CHAR_COMMA);
            repeat (wide ? $urandom_range(0, 1) : $urandom_range(1, 3))
                file_bytes.push_back(text_byte());
        end
        // Without a newline the file is header only.
        if (nrows > 0 || final_nl)
            file_bytes.push_back(CHAR_NL);
        for (r = 0; r < nrows; r++) begin
            case ($urandom_range(0, 5))
                0:       ncells = ncols + $urandom_range(1, 2);   // extra cells
                1:       ncells = $urandom_range(0, ncols - 1);   // short row or empty line
                default: ncells = ncols;
            endcase
            for (c = 0; c < ncells; c++) begin
                if (c > 0)
                    file_bytes.push_back(CHAR_COMMA);
                push_cell(wide);
            end
            if (r < nrows - 1 || final_nl)
                file_bytes.push_back(CHAR_NL);
        end
        if ($urandom_range(0, 5) == 0) begin
            k = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[k] = 8'($urandom_range(0, 255));
        end
    endtask

    function automatic logic [7:0] pick_rows();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd3;
            4:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int base;
        int nfiles;
        rows_cfg = RESET_ROWS;
        clear_model();

        // Directed files, in order:
        //  - a lone 0xFF byte: header only, one integer column
        //  - a lone NUL byte: same, at the bottom of the byte range
        //  - dot-only cell (float), negative integer, an extra cell, an empty line
        //    that turns column 0 into a string, and a text cell closed by the end byte
        //  - one sampled row, so the following row is skipped; ends on a newline
        //  - no sampled rows at all
        add_typed(8'hFF, TYPE_INT);
        add_typed(8'h00, TYPE_INT);
        add_text("a,b\n.,-7,9\n\nq", 1'b0, 8'd0);
        add_text("h\n1\nz\n", 1'b1, 8'd1);
        add_text("c,d\n5,x", 1'b1, 8'd0);

        in_gap_pct    = 20;
        out_stall_pct = 30;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].set_rows)
                write_rows(dir_rows[k].rows_val);
            drive_item(dir_rows[k].data, dir_rows[k].eof, dir_rows[k].typed, dir_rows[k].typ);
            if (dir_rows[k].eof)
                wait_idle();
        end

        // Random files; each one changes the idling pattern and sometimes the register.
        base   = live_items;
        nfiles = 0;
        while (live_items - base < RAND_ITEMS || nfiles < MIN_FILES) begin
            idle_en = (live_items - base) < CALM_AFTER;
            case ($urandom_range(0, 2))
                0:       in_gap_pct = 0;
                1:       in_gap_pct = 15;
                default: in_gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       out_stall_pct = 0;
                1:       out_stall_pct = 15;
                default: out_stall_pct = 40;
            endcase
            if (nfiles == 0)
                write_rows(8'd255);
            else if ($urandom_range(0, 2) == 0)
                write_rows(pick_rows());
            build_csv(nfiles == 2);
            send_file();
            nfiles++;
        end

        idle_en = 1'b0;
        repeat (20) @(negedge i_clk);
        if (err_cnt == 0 && exp_cols.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
